@@ rtl/core/assert_macros.svh @@
// assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define SARE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sare assertion failed");

// implication into the next cycle
`define SARE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sare assertion failed");

`endif

@@ rtl/core/sare_pkg.sv @@
`timescale 1ns / 1ps

package sare_pkg;

    localparam int MAX_RECS    = 4;
    localparam int REC_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
    localparam logic [15:0] WORD_MAX     = 16'hFFFF;
    localparam logic [16:0] CNT_MAX      = 17'h1FFFF;

    localparam logic MODE_OPAQUE  = 1'b0;
    localparam logic MODE_PARTIAL = 1'b1;

    typedef struct packed {
        logic [15:0] color;
        logic [7:0]  alpha;
        logic        last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [17:0] byte_offset;
        logic [15:0] value;
        logic        is_byte;
        logic        overflow;
        logic [17:0] total_bytes;
        logic        last_record;
    } write_t;

    typedef struct packed {
        write_t [MAX_RECS-1:0]  recs;
        logic [REC_IDX_W-1:0]   last_idx;
    } cmd_t;

    function automatic write_t make_rec(
        input logic [17:0] off,
        input logic [15:0] val,
        input logic        isb
    );
        write_t r;
        r             = '0;
        r.byte_offset = off;
        r.value       = val;
        r.is_byte     = isb;
        return r;
    endfunction

    function automatic write_t make_count(
        input logic [17:0] off,
        input logic [16:0] cnt
    );
        write_t r;
        r             = '0;
        r.byte_offset = off;
        r.value       = cnt[15:0];
        r.overflow    = (cnt > {1'b0, WORD_MAX});
        return r;
    endfunction

    function automatic logic [16:0] inc_sat(input logic [16:0] c);
        return (c != CNT_MAX) ? c + 17'd1 : c;
    endfunction

endpackage

@@ rtl/core/sare_front.sv @@
`timescale 1ns / 1ps

module sare_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_data,
    input  logic             pix_valid,
    output logic             pix_ready,
    input  sare_pkg::pixel_t pix,
    input  logic             q_full,
    output logic             q_push,
    output sare_pkg::cmd_t   q_data
);

    logic        mode_reg;
    logic        run_reg;
    logic        run_next;
    logic [16:0] skip_reg;
    logic [16:0] skip_next;
    logic [16:0] litc_reg;
    logic [16:0] litc_next;
    logic [17:0] wp_reg;
    logic [17:0] wp_next;
    logic [17:0] slot_reg;
    logic [17:0] slot_next;

    logic                                        lit;
    logic [2:0]                                  n;
    logic [2:0]                                  n_m1;
    sare_pkg::write_t [sare_pkg::MAX_RECS-1:0]   recs;
    logic                                        accept;

    assign pix_ready = !q_full;
    assign accept    = pix_valid && pix_ready;

    always_comb
    begin
        recs      = '0;
        n         = 3'd0;
        run_next  = run_reg;
        skip_next = skip_reg;
        litc_next = litc_reg;
        wp_next   = wp_reg;
        slot_next = slot_reg;

        if (mode_reg == sare_pkg::MODE_PARTIAL)
            lit = (pix.alpha != sare_pkg::ALPHA_CLEAR) && (pix.alpha != sare_pkg::ALPHA_OPAQUE);
        else
            lit = (pix.alpha == sare_pkg::ALPHA_OPAQUE);

        if (lit)
        begin
            if (!run_next)
            begin
                recs[n[1:0]] = sare_pkg::make_count(wp_next, skip_next);
                n            = n + 3'd1;
                slot_next    = wp_next + 18'd2;
                wp_next      = wp_next + 18'd4;
                skip_next    = '0;
                litc_next    = '0;
                run_next     = 1'b1;
            end
            recs[n[1:0]] = sare_pkg::make_rec(wp_next, pix.color, 1'b0);
            n            = n + 3'd1;
            wp_next      = wp_next + 18'd2;
            if (mode_reg == sare_pkg::MODE_PARTIAL)
            begin
                recs[n[1:0]] = sare_pkg::make_rec(wp_next, {8'd0, pix.alpha}, 1'b1);
                n            = n + 3'd1;
                wp_next      = wp_next + 18'd1;
            end
            litc_next = sare_pkg::inc_sat(litc_next);
        end
        else
        begin
            if (run_next)
            begin
                recs[n[1:0]] = sare_pkg::make_count(slot_next, litc_next);
                n            = n + 3'd1;
                run_next     = 1'b0;
                litc_next    = '0;
                skip_next    = '0;
            end
            skip_next = sare_pkg::inc_sat(skip_next);
        end

        if (pix.last_pixel)
        begin
            if (run_next)
            begin
                recs[n[1:0]] = sare_pkg::make_count(slot_next, litc_next);
                n            = n + 3'd1;
            end
            else
            begin
                recs[n[1:0]] = sare_pkg::make_count(wp_next, skip_next);
                n            = n + 3'd1;
                recs[n[1:0]] = sare_pkg::make_rec(wp_next + 18'd2, 16'd0, 1'b0);
                n            = n + 3'd1;
                wp_next      = wp_next + 18'd4;
            end
        end

        n_m1 = n - 3'd1;
        recs[n_m1[1:0]].last_record = 1'b1;
        if (pix.last_pixel)
        begin
            recs[n_m1[1:0]].total_bytes = wp_next;
            run_next  = 1'b0;
            skip_next = '0;
            litc_next = '0;
            wp_next   = '0;
            slot_next = '0;
        end
    end

    assign q_push        = accept && (n != 3'd0);
    assign q_data.recs   = recs;
    assign q_data.last_idx = n_m1[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= sare_pkg::MODE_OPAQUE;
            run_reg  <= 1'b0;
            skip_reg <= '0;
            litc_reg <= '0;
            wp_reg   <= '0;
            slot_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_data;
            if (accept)
            begin
                run_reg  <= run_next;
                skip_reg <= skip_next;
                litc_reg <= litc_next;
                wp_reg   <= wp_next;
                slot_reg <= slot_next;
            end
        end
    end

endmodule

@@ rtl/core/sare_queue.sv @@
`timescale 1ns / 1ps

module sare_queue
#(
    parameter int DEPTH = sare_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sare_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output sare_pkg::cmd_t head,
    output logic           empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sare_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/core/sare_back.sv @@
`timescale 1ns / 1ps

module sare_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  sare_pkg::cmd_t   q_head,
    output logic             q_pop,
    output logic             wr_valid,
    input  logic             wr_ready,
    output sare_pkg::write_t wr
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [sare_pkg::REC_IDX_W-1:0] idx_reg;
    logic [sare_pkg::REC_IDX_W-1:0] idx_next;
    sare_pkg::write_t               out_reg;
    sare_pkg::write_t               out_next;
    logic                           load;

    assign load = !valid_reg || wr_ready;

    always_comb
    begin
        q_pop      = 1'b0;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        if (load)
        begin
            if (!q_empty)
            begin
                out_next   = q_head.recs[idx_reg];
                valid_next = 1'b1;
                if (idx_reg == q_head.last_idx)
                begin
                    q_pop    = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign wr_valid = valid_reg;
    assign wr       = out_reg;

endmodule

@@ rtl/core/sprite_alpha_rle_encoder_top.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake             payload
// cfg       in   cfg_valid/cfg_ready   cfg_data (mode)
// pix       in   pix_valid/pix_ready   pix (color, alpha, last_pixel)
// wr        out  wr_valid/wr_ready     wr (one stream write)
//
// each accepted pixel yields zero to four writes, one per cycle at wr while wr_ready is high
// sustained throughput is set by the single write port
// a command queue of QUEUE_DEPTH entries lets pix and wr stall independently
// asynchronous active-low reset clears mode, run state, queue and output valid
// cfg_ready is always high

module sprite_alpha_rle_encoder_top
#(
    parameter int QUEUE_DEPTH = sare_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data,
    input  logic             pix_valid,
    output logic             pix_ready,
    input  sare_pkg::pixel_t pix,
    output logic             wr_valid,
    input  logic             wr_ready,
    output sare_pkg::write_t wr
);

    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    sare_pkg::cmd_t q_data;
    sare_pkg::cmd_t q_head;

    assign cfg_ready = 1'b1;

    sare_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    sare_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    sare_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr       (wr)
    );

endmodule

@@ rtl/core/sare_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sare_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             pix_valid,
    input logic             pix_ready,
    input sare_pkg::pixel_t pix,
    input logic             wr_valid,
    input logic             wr_ready,
    input sare_pkg::write_t wr
);

    `SARE_ASSERT_NEXT(a_pix_hold, clk, rst_n, pix_valid && !pix_ready, pix_valid && $stable(pix))
    `SARE_ASSERT_NEXT(a_wr_hold, clk, rst_n, wr_valid && !wr_ready, wr_valid && $stable(wr))
    `SARE_ASSERT_SAME(a_total_last, clk, rst_n, wr_valid && !wr.last_record, wr.total_bytes == '0)
    `SARE_ASSERT_SAME(a_byte_no_ovf, clk, rst_n, wr_valid && wr.is_byte, !wr.overflow)
    `SARE_ASSERT_SAME(a_byte_narrow, clk, rst_n, wr_valid && wr.is_byte, wr.value[15:8] == 8'd0)

endmodule

bind sprite_alpha_rle_encoder_top sare_checker u_sare_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 100000;
    localparam int DRAIN_WAIT  = 8;
    localparam int MAX_REPORTS = 200;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_data;
    logic             pix_valid;
    logic             pix_ready;
    sare_pkg::pixel_t pix;
    logic             wr_valid;
    logic             wr_ready = 1'b0;
    sare_pkg::write_t wr;

    // encoder state mirrored by the testbench
    logic        enc_mode;
    logic        in_literal;
    logic [16:0] skip_run;
    logic [16:0] literal_run;
    logic [17:0] stream_pos;
    logic [17:0] count_slot;

    sare_pkg::write_t pending_writes[$];
    int               send_idle_pct;
    int               recv_idle_pct;
    int               mismatch_count;
    int               cycle_count = 0;

    sprite_alpha_rle_encoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .wr_valid  (wr_valid),
        .wr_ready  (wr_ready),
        .wr        (wr)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sprite_alpha_rle_encoder_top test failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        wr_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic sare_pkg::write_t data_write(input logic [17:0] off,
                                                    input logic [15:0] val,
                                                    input logic isb);
        sare_pkg::write_t rec;
        rec             = '0;
        rec.byte_offset = off;
        rec.value       = val;
        rec.is_byte     = isb;
        return rec;
    endfunction

    function automatic sare_pkg::write_t count_write(input logic [17:0] off,
                                                     input logic [16:0] cnt);
        sare_pkg::write_t rec;
        rec          = data_write(off, cnt[15:0], 1'b0);
        rec.overflow = cnt[16];
        return rec;
    endfunction

    function automatic logic [16:0] bump_count(input logic [16:0] cnt);
        return (cnt == sare_pkg::CNT_MAX) ? cnt : cnt + 17'd1;
    endfunction

    task automatic encode_pixel(input sare_pkg::pixel_t p);
        sare_pkg::write_t recs[$];
        sare_pkg::write_t rec;
        logic             literal;
        if (enc_mode == sare_pkg::MODE_OPAQUE)
            literal = (p.alpha == sare_pkg::ALPHA_OPAQUE);
        else
            literal = (p.alpha != sare_pkg::ALPHA_CLEAR) && (p.alpha != sare_pkg::ALPHA_OPAQUE);
        if (literal)
        begin
            if (!in_literal)
            begin
                recs.push_back(count_write(stream_pos, skip_run));
                count_slot  = stream_pos + 18'd2;
                stream_pos  = stream_pos + 18'd4;
                skip_run    = '0;
                literal_run = '0;
                in_literal  = 1'b1;
            end
            recs.push_back(data_write(stream_pos, p.color, 1'b0));
            stream_pos = stream_pos + 18'd2;
            if (enc_mode != sare_pkg::MODE_OPAQUE)
            begin
                recs.push_back(data_write(stream_pos, {8'h00, p.alpha}, 1'b1));
                stream_pos = stream_pos + 18'd1;
            end
            literal_run = bump_count(literal_run);
        end
        else
        begin
            if (in_literal)
            begin
                recs.push_back(count_write(count_slot, literal_run));
                in_literal  = 1'b0;
                literal_run = '0;
                skip_run    = '0;
            end
            skip_run = bump_count(skip_run);
        end
        if (p.last_pixel)
        begin
            if (in_literal)
            begin
                recs.push_back(count_write(count_slot, literal_run));
            end
            else
            begin
                recs.push_back(count_write(stream_pos, skip_run));
                recs.push_back(data_write(stream_pos + 18'd2, 16'h0000, 1'b0));
                stream_pos = stream_pos + 18'd4;
            end
            rec             = recs.pop_back();
            rec.total_bytes = stream_pos;
            recs.push_back(rec);
            in_literal  = 1'b0;
            skip_run    = '0;
            literal_run = '0;
            stream_pos  = '0;
            count_slot  = '0;
        end
        if (recs.size() > 0)
        begin
            rec             = recs.pop_back();
            rec.last_record = 1'b1;
            recs.push_back(rec);
        end
        foreach (recs[i])
            pending_writes.push_back(recs[i]);
    endtask

    task automatic check_write(input sare_pkg::write_t got);
        sare_pkg::write_t want;
        if (pending_writes.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
            begin
                $display("%0t: expected no write", $time);
                $display("%0t: actual   off=%h val=%h byte=%b ovf=%b total=%h last=%b",
                         $time, got.byte_offset, got.value, got.is_byte, got.overflow,
                         got.total_bytes, got.last_record);
            end
        end
        else
        begin
            want = pending_writes.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: expected off=%h val=%h byte=%b ovf=%b total=%h last=%b",
                             $time, want.byte_offset, want.value, want.is_byte,
                             want.overflow, want.total_bytes, want.last_record);
                    $display("%0t: actual   off=%h val=%h byte=%b ovf=%b total=%h last=%b",
                             $time, got.byte_offset, got.value, got.is_byte,
                             got.overflow, got.total_bytes, got.last_record);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && wr_valid && wr_ready)
            check_write(wr);
    end

    // called at a falling edge, returns at a falling edge with pix_valid still high
    task automatic send_pixel(input logic [15:0] color, input logic [7:0] alpha,
                              input logic last);
        sare_pkg::pixel_t p;
        p.color      = color;
        p.alpha      = alpha;
        p.last_pixel = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix       <= p;
        pix_valid <= 1'b1;
        do
            @(posedge clk);
        while (!pix_ready);
        encode_pixel(p);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        pix_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_mode(input logic m);
        wait_idle();
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        enc_mode = m;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_opaque_basics();
        write_mode(sare_pkg::MODE_OPAQUE);
        send_pixel(16'h1234, 8'hFF, 1'b1);
        send_pixel(16'hABCD, 8'h00, 1'b1);
        send_pixel(16'h0000, 8'h00, 1'b0);
        send_pixel(16'hFFFF, 8'h80, 1'b0);
        send_pixel(16'h0000, 8'hFF, 1'b0);
        send_pixel(16'hFFFF, 8'hFF, 1'b0);
        send_pixel(16'h5555, 8'hFE, 1'b0);
        send_pixel(16'hAAAA, 8'hFF, 1'b1);
    endtask

    task automatic test_partial_basics();
        write_mode(sare_pkg::MODE_PARTIAL);
        send_pixel(16'h0F0F, 8'h01, 1'b1);
        send_pixel(16'hF0F0, 8'hFF, 1'b1);
        send_pixel(16'h0000, 8'h00, 1'b0);
        send_pixel(16'hFFFF, 8'hFF, 1'b0);
        send_pixel(16'h1111, 8'h01, 1'b0);
        send_pixel(16'hFFFF, 8'hFE, 1'b0);
        send_pixel(16'h2222, 8'h80, 1'b0);
        send_pixel(16'h3333, 8'h00, 1'b0);
        send_pixel(16'h4444, 8'h7F, 1'b1);
    endtask

    // mode flips in the middle of a sprite
    task automatic test_mode_switch();
        write_mode(sare_pkg::MODE_OPAQUE);
        send_pixel(16'hC0DE, 8'hFF, 1'b0);
        write_mode(sare_pkg::MODE_PARTIAL);
        send_pixel(16'hBEEF, 8'hFF, 1'b0);
        send_pixel(16'h7777, 8'h40, 1'b0);
        write_mode(sare_pkg::MODE_OPAQUE);
        send_pixel(16'h8888, 8'h40, 1'b1);
    endtask

    function automatic logic [7:0] pick_alpha();
        int r;
        r = $urandom_range(9);
        if (r < 3)
            return sare_pkg::ALPHA_OPAQUE;
        else if (r < 5)
            return sare_pkg::ALPHA_CLEAR;
        else if (r < 8)
            return 8'($urandom_range(254, 1));
        else
            return 8'($urandom_range(255));
    endfunction

    task automatic test_random_sprites(input int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(3) == 0)
                write_mode(1'($urandom_range(1)));
            len = $urandom_range(10, 1);
            for (int i = 0; i < len; i++)
            begin
                send_pixel(16'($urandom), pick_alpha(), i == len - 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 1'b0;
        pix_valid      = 1'b0;
        pix            = '0;
        send_idle_pct  = 15;
        recv_idle_pct  = 76;
        mismatch_count = 0;
        enc_mode       = sare_pkg::MODE_OPAQUE;
        in_literal     = 1'b0;
        skip_run       = '0;
        literal_run    = '0;
        stream_pos     = '0;
        count_slot     = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_opaque_basics();
        test_partial_basics();
        test_random_sprites(45);

        send_idle_pct = 76;
        recv_idle_pct = 15;
        test_mode_switch();
        test_random_sprites(45);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sprites(40);

        wait_idle();
        if (mismatch_count == 0 && pending_writes.size() == 0)
            $display("sprite_alpha_rle_encoder_top test passed");
        else
            $display("sprite_alpha_rle_encoder_top test failed");
        $finish;
    end

endmodule
